### src/dcpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcpc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int AMP_W    = 11;
    localparam int OFFSET_W = 13;
    localparam int SUM_W    = 15;

    localparam logic [SAMPLE_W-1:0] UPPER_RESET = 12'd2800;
    localparam logic [SAMPLE_W-1:0] LOWER_RESET = 12'd2200;
    localparam logic [SAMPLE_W-1:0] MIN_START   = 12'd1500;
    localparam logic [SAMPLE_W:0]   MARGIN      = 13'd2;

    localparam logic [2:0] CROSSINGS_PER_ROUND    = 3'd5;
    localparam logic [2:0] ROUNDS_PER_CALIBRATION = 3'd5;

    // floor(x / 5) == (x * 26215) >> 17 for every x below 2**15.
    localparam logic [SUM_W-1:0] DIV5_MULT  = 15'd26215;
    localparam int               DIV5_SHIFT = 17;

    typedef enum logic [0:0] {
        REG_UPPER_THRESHOLD = 1'b0,
        REG_LOWER_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [SUM_W-1:0] max_one;
        logic [SUM_W-1:0] max_two;
        logic [SUM_W-1:0] min_one;
        logic [SUM_W-1:0] min_two;
    } sums_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] max_one;
        logic [SAMPLE_W-1:0] max_two;
        logic [SAMPLE_W-1:0] min_one;
        logic [SAMPLE_W-1:0] min_two;
    } averages_t;

    function automatic logic [SAMPLE_W-1:0] div5(input logic [SUM_W-1:0] x);
        logic [2*SUM_W-1:0] prod;
        prod = x * DIV5_MULT;
        return prod[DIV5_SHIFT+SAMPLE_W-1:DIV5_SHIFT];
    endfunction

endpackage

`default_nettype wire

### src/dual_channel_peak_calibration.sv
`timescale 1ns / 1ps
`default_nettype none

// Peak calibration for a pair of 12-bit sensor channels. The block takes one sample
// pair per clock cycle while s_tready is high and updates the tracked extremes,
// crossing marks and counters in that same cycle. Five crossings of channel one make a
// round, five rounds make a calibration, and the last sample pair of a calibration
// produces one result transaction through the sum register, the averaging multipliers
// and the output register. s_tready stays high unless the three-entry result pipeline
// is full and m_tready holds it back. The user must write thresholds through the cfg
// port only while the block is idle (not enforced by the block); they persist across calibrations.
module dual_channel_peak_calibration (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [11:0] cfg_wdata,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // sample_one [11:0], sample_two [23:12]
    input  wire logic [23:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // amplitude_one [10:0], amplitude_two [21:11], center_one [33:22],
    // center_two [45:34], center_offset [58:46], zero padding [63:59]
    output logic [63:0]      m_tdata
);

    localparam int SW = dcpc_pkg::SAMPLE_W;

    logic [SW-1:0] upper_reg, lower_reg;
    logic [SW-1:0] max1_reg, max2_reg, min1_reg, min2_reg;
    logic          up_reg, down_reg;
    logic [2:0]    cross_reg, round_reg;
    dcpc_pkg::sums_t sums_reg;

    logic              p1_valid_reg, p1_valid_next;
    dcpc_pkg::sums_t   p1_sums_reg;
    logic              p2_valid_reg, p2_valid_next;
    dcpc_pkg::averages_t p2_avg_reg;
    logic              m_valid_reg, m_valid_next;
    logic [63:0]       m_data_reg, m_data_next;

    logic [SW-1:0] s1, s2;
    logic          peak1, trough1, peak2, trough2;
    logic [SW-1:0] max1_next, max2_next, min1_next, min2_next;
    logic          up_set, down_set, crossing;
    logic [2:0]    cross_inc, round_inc;
    logic          round_end, cal_end, accept;
    dcpc_pkg::sums_t sums_add;
    logic          out_free, p2_free, p1_adv, p2_adv;

    logic [SW:0]   amp1_diff, amp2_diff, c1_sum, c2_sum;
    logic [dcpc_pkg::AMP_W-1:0]    amp1, amp2;
    logic [SW-1:0] c1, c2;
    logic [dcpc_pkg::OFFSET_W-1:0] offset;

    assign s1 = s_tdata[11:0];
    assign s2 = s_tdata[23:12];

    always_comb begin
        peak1   = {1'b0, s1} >= ({1'b0, upper_reg} + dcpc_pkg::MARGIN);
        trough1 = ({1'b0, s1} + dcpc_pkg::MARGIN) <= {1'b0, lower_reg};
        peak2   = {1'b0, s2} >= ({1'b0, upper_reg} + dcpc_pkg::MARGIN);
        trough2 = ({1'b0, s2} + dcpc_pkg::MARGIN) <= {1'b0, lower_reg};

        max1_next = (peak1 && ({1'b0, s1} >= ({1'b0, max1_reg} + dcpc_pkg::MARGIN)))
                    ? s1 : max1_reg;
        max2_next = (peak2 && ({1'b0, s2} >= ({1'b0, max2_reg} + dcpc_pkg::MARGIN)))
                    ? s2 : max2_reg;
        min1_next = (trough1 && (({1'b0, s1} + dcpc_pkg::MARGIN) <= {1'b0, min1_reg}))
                    ? s1 : min1_reg;
        min2_next = (trough2 && (({1'b0, s2} + dcpc_pkg::MARGIN) <= {1'b0, min2_reg}))
                    ? s2 : min2_reg;

        up_set    = up_reg | peak1;
        down_set  = down_reg | trough1;
        crossing  = up_set & down_set;
        cross_inc = crossing ? cross_reg + 3'd1 : cross_reg;
        round_end = (cross_inc == dcpc_pkg::CROSSINGS_PER_ROUND);
        round_inc = round_reg + 3'd1;
        cal_end   = round_end && (round_inc == dcpc_pkg::ROUNDS_PER_CALIBRATION);

        sums_add.max_one = sums_reg.max_one + {3'b000, max1_next};
        sums_add.max_two = sums_reg.max_two + {3'b000, max2_next};
        sums_add.min_one = sums_reg.min_one + {3'b000, min1_next};
        sums_add.min_two = sums_reg.min_two + {3'b000, min2_next};
    end

    assign out_free = !m_valid_reg || m_tready;
    assign p2_free  = !p2_valid_reg || out_free;
    assign p2_adv   = p2_valid_reg && out_free;
    assign p1_adv   = p1_valid_reg && p2_free;
    assign s_tready = !p1_valid_reg || p2_free;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= dcpc_pkg::UPPER_RESET;
            lower_reg <= dcpc_pkg::LOWER_RESET;
        end else if (cfg_we) begin
            unique case (dcpc_pkg::cfg_index_t'(cfg_index))
                dcpc_pkg::REG_UPPER_THRESHOLD: upper_reg <= cfg_wdata;
                dcpc_pkg::REG_LOWER_THRESHOLD: lower_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max1_reg  <= '0;
            max2_reg  <= '0;
            min1_reg  <= dcpc_pkg::MIN_START;
            min2_reg  <= dcpc_pkg::MIN_START;
            up_reg    <= 1'b0;
            down_reg  <= 1'b0;
            cross_reg <= '0;
            round_reg <= '0;
            sums_reg  <= '0;
        end else if (accept) begin
            up_reg   <= crossing ? 1'b0 : up_set;
            down_reg <= crossing ? 1'b0 : down_set;
            if (round_end) begin
                cross_reg <= '0;
                max1_reg  <= '0;
                max2_reg  <= '0;
                min1_reg  <= dcpc_pkg::MIN_START;
                min2_reg  <= dcpc_pkg::MIN_START;
                if (cal_end) begin
                    round_reg <= '0;
                    sums_reg  <= '0;
                end else begin
                    round_reg <= round_inc;
                    sums_reg  <= sums_add;
                end
            end else begin
                cross_reg <= cross_inc;
                max1_reg  <= max1_next;
                max2_reg  <= max2_next;
                min1_reg  <= min1_next;
                min2_reg  <= min2_next;
            end
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg && !p1_adv;
        if (accept && cal_end) begin
            p1_valid_next = 1'b1;
        end
        p2_valid_next = p2_valid_reg && !p2_adv;
        if (p1_adv) begin
            p2_valid_next = 1'b1;
        end
        m_valid_next = m_valid_reg && !m_tready;
        if (p2_adv) begin
            m_valid_next = 1'b1;
        end
    end

    always_comb begin
        amp1_diff = {1'b0, p2_avg_reg.max_one} - {1'b0, p2_avg_reg.min_one};
        amp2_diff = {1'b0, p2_avg_reg.max_two} - {1'b0, p2_avg_reg.min_two};
        amp1 = (p2_avg_reg.max_one >= p2_avg_reg.min_one) ? amp1_diff[SW-1:1] : '0;
        amp2 = (p2_avg_reg.max_two >= p2_avg_reg.min_two) ? amp2_diff[SW-1:1] : '0;
        c1_sum = {1'b0, p2_avg_reg.max_one} + {1'b0, p2_avg_reg.min_one};
        c2_sum = {1'b0, p2_avg_reg.max_two} + {1'b0, p2_avg_reg.min_two};
        c1 = c1_sum[SW:1];
        c2 = c2_sum[SW:1];
        offset = {1'b0, c1} - {1'b0, c2};
        m_data_next = {5'b00000, offset, c2, c1, amp2, amp1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && cal_end) begin
            p1_sums_reg <= sums_add;
        end
        if (p1_adv) begin
            p2_avg_reg.max_one <= dcpc_pkg::div5(p1_sums_reg.max_one);
            p2_avg_reg.max_two <= dcpc_pkg::div5(p1_sums_reg.max_two);
            p2_avg_reg.min_one <= dcpc_pkg::div5(p1_sums_reg.min_one);
            p2_avg_reg.min_two <= dcpc_pkg::div5(p1_sums_reg.min_two);
        end
        if (p2_adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cross_reg < dcpc_pkg::CROSSINGS_PER_ROUND && round_reg < dcpc_pkg::ROUNDS_PER_CALIBRATION)
        else $error("crossing or round counter passed its limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cal_end |=> p1_valid_reg && round_reg == 3'd0 && sums_reg == '0)
        else $error("calibration end did not restart the sums");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[58:46] == ({1'b0, m_tdata[33:22]} - {1'b0, m_tdata[45:34]}))
        else $error("center offset does not match the two centers");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !p1_valid_reg |-> s_tready)
        else $error("input stalled with an empty result pipeline");

endmodule

`default_nettype wire
